// ----- sv/ts_description_section_parser_core_assert.svh -----
// Assertion macros shared by the section parser RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef TS_DESCRIPTION_SECTION_PARSER_CORE_ASSERT_SVH
`define TS_DESCRIPTION_SECTION_PARSER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TSD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TSD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TSD_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TSD_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- sv/tsdsp_pkg.sv -----
// Shared types, constants and the CRC step for the section parser.
// No dependencies.
`timescale 1ns / 1ps
package tsdsp_pkg;
    localparam int MaxDesc = 32;
    localparam int IdxW = $clog2(MaxDesc);
    localparam int CntW = $clog2(MaxDesc + 1);
    localparam logic [31:0] CrcPoly = 32'h04C11DB7;
    localparam logic [12:0] PosMax = 13'd8191;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_CRC = 2'd1, ST_SHORT = 2'd2, ST_OVF = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_TAG = 2'd0, PH_LEN = 2'd1, PH_SKIP = 2'd2
    } phase_t;

    // Controller to datapath.
    typedef struct packed {
        logic take_byte;
        logic load_out;
        logic out_desc;
        logic out_last;
        logic clear;
        logic [IdxW-1:0] rd_idx;
        logic rd_en;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic pass;
        logic [CntW-1:0] count;
    } stat_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'd0};
        for (int i = 0; i < 8; i++) begin
            c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
        end
        return c;
    endfunction
endpackage

// ----- sv/tsdsp_ram.sv -----
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module tsdsp_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata <= mem[raddr];
    end
endmodule

// ----- sv/tsdsp_datapath.sv -----
// Datapath: CRC, header store, descriptor walker, table and output register.
// Depends on tsdsp_pkg and tsdsp_ram.
`timescale 1ns / 1ps
`include "ts_description_section_parser_core_assert.svh"
module tsdsp_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [12:0]        min_bytes,
    input  logic [7:0]         byte_in,
    input  tsdsp_pkg::cmd_t    cmd,
    output tsdsp_pkg::stat_t   stat,
    output logic [95:0]        rec_data
);
    localparam int IW = tsdsp_pkg::IdxW;
    localparam int CW = tsdsp_pkg::CntW;

    logic [12:0] pos_reg, pos_next;
    logic [31:0] crc_reg, crc_next, tail_reg, tail_next;
    logic [63:0] hdr_reg, hdr_next;
    tsdsp_pkg::phase_t ph_reg, ph_next;
    logic [8:0]  skip_reg, skip_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic ovf_reg, ovf_next;
    logic [95:0] rec_reg, rec_next;

    // Section state after the current byte, before any end-of-section clear.
    logic [31:0] crc_upd, tail_upd;
    logic [63:0] hdr_upd;
    logic [CW-1:0] cnt_upd;
    logic ovf_upd;

    // Tag/offset and length are kept in separate RAMs so each write is one word.
    logic tag_we, len_we;
    logic [IW-1:0] tag_a, len_a;
    logic [19:0] tag_q;
    logic [7:0]  len_q;
    logic [7:0]  len_wd;

    // A tag clears its length entry; the length byte itself fills it later.
    assign len_wd = (ph_reg == tsdsp_pkg::PH_LEN) ? byte_in : 8'd0;

    tsdsp_ram #(.Width(20), .Depth(tsdsp_pkg::MaxDesc)) u_tag (
        .aclk, .we(tag_we), .waddr(tag_a), .wdata({byte_in, pos_reg[11:0]}),
        .re(cmd.rd_en), .raddr(cmd.rd_idx), .rdata(tag_q));
    tsdsp_ram #(.Width(8), .Depth(tsdsp_pkg::MaxDesc)) u_len (
        .aclk, .we(len_we), .waddr(len_a), .wdata(len_wd),
        .re(cmd.rd_en), .raddr(cmd.rd_idx), .rdata(len_q));

    logic [11:0] sl;
    logic in_loop;
    logic [13:0] total;
    logic [1:0]  st_c;
    logic        pass_c;
    assign sl = {hdr_reg[51:48], hdr_reg[47:40]};
    assign in_loop = (pos_reg >= 13'd8) && ({1'b0, pos_reg} + 14'd1 < {2'b0, sl});
    assign total = (pos_reg < tsdsp_pkg::PosMax) ? {1'b0, pos_reg} + 14'd1
                                                 : {1'b0, tsdsp_pkg::PosMax};

    always_comb begin
        pos_next = pos_reg; crc_next = crc_reg; tail_next = tail_reg; hdr_next = hdr_reg;
        ph_next = ph_reg; skip_next = skip_reg; cnt_next = cnt_reg; ovf_next = ovf_reg;
        tag_we = 1'b0; len_we = 1'b0;
        tag_a = cnt_reg[IW-1:0];
        len_a = IW'(cnt_reg - CW'(1));
        if (cmd.take_byte) begin
            if (pos_reg >= 13'd4) crc_next = tsdsp_pkg::crc_byte(crc_reg, tail_reg[31:24]);
            tail_next = {tail_reg[23:0], byte_in};
            if (pos_reg < 13'd8)
                hdr_next[8*(7-pos_reg[2:0]) +: 8] = byte_in;
            if (in_loop) begin
                unique case (ph_reg)
                    tsdsp_pkg::PH_LEN: begin
                        len_we = !ovf_reg && cnt_reg != '0;
                        skip_next = {1'b0, byte_in};
                        ph_next = (byte_in == 8'd0) ? tsdsp_pkg::PH_TAG : tsdsp_pkg::PH_SKIP;
                    end
                    tsdsp_pkg::PH_SKIP: begin
                        if (skip_reg <= 9'd1) ph_next = tsdsp_pkg::PH_TAG;
                        if (skip_reg != 9'd0) skip_next = skip_reg - 9'd1;
                    end
                    default: begin
                        if (cnt_reg < CW'(tsdsp_pkg::MaxDesc)) begin
                            tag_we = 1'b1;
                            // Length stays 0 unless its byte arrives.
                            len_we = 1'b1; len_a = cnt_reg[IW-1:0];
                            cnt_next = cnt_reg + CW'(1);
                        end else ovf_next = 1'b1;
                        ph_next = tsdsp_pkg::PH_LEN;
                    end
                endcase
            end
            pos_next = total[12:0];
        end
        crc_upd = crc_next; tail_upd = tail_next; hdr_upd = hdr_next;
        cnt_upd = cnt_next; ovf_upd = ovf_next;
        if (cmd.clear) begin
            pos_next = '0; crc_next = '1; tail_next = '0; hdr_next = '0;
            ph_next = tsdsp_pkg::PH_TAG; skip_next = '0; cnt_next = '0; ovf_next = 1'b0;
        end
    end

    always_comb begin
        if (total < 14'd4 || total < {1'b0, min_bytes}) st_c = tsdsp_pkg::ST_SHORT;
        else if (crc_upd != tail_upd) st_c = tsdsp_pkg::ST_CRC;
        else if (ovf_upd) st_c = tsdsp_pkg::ST_OVF;
        else st_c = tsdsp_pkg::ST_OK;
    end
    assign pass_c = (st_c == tsdsp_pkg::ST_OK) || (st_c == tsdsp_pkg::ST_OVF);

    // Summary fields come from the state as updated by the last byte.
    always_comb begin
        rec_next = rec_reg;
        if (cmd.load_out && !cmd.out_desc) begin
            rec_next = '0;
            rec_next[2:1] = st_c;
            if (pass_c) begin
                rec_next[10:3]  = hdr_upd[63:56];
                rec_next[14:11] = hdr_upd[55:52];
                rec_next[26:15] = {hdr_upd[51:48], hdr_upd[47:40]};
                rec_next[44:27] = {hdr_upd[39:32], hdr_upd[31:24], hdr_upd[23:22]};
                rec_next[49:45] = hdr_upd[21:17];
                rec_next[50]    = hdr_upd[16];
                rec_next[58:51] = hdr_upd[15:8];
                rec_next[66:59] = hdr_upd[7:0];
                rec_next[94:67] = 28'(cnt_upd);
            end
            rec_next[95] = !pass_c || cnt_upd == '0;
        end else if (cmd.load_out) begin
            rec_next = '0;
            rec_next[0] = 1'b1;
            rec_next[94:67] = {tag_q[19:12], len_q, tag_q[11:0]};
            rec_next[95] = cmd.out_last;
        end
    end
    assign rec_data = rec_reg;

    assign stat.pass  = pass_c;
    assign stat.count = cnt_upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0; crc_reg <= '1; tail_reg <= '0; hdr_reg <= '0;
            ph_reg <= tsdsp_pkg::PH_TAG; skip_reg <= '0; cnt_reg <= '0; ovf_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next; crc_reg <= crc_next; tail_reg <= tail_next;
            hdr_reg <= hdr_next; ph_reg <= ph_next; skip_reg <= skip_next;
            cnt_reg <= cnt_next; ovf_reg <= ovf_next;
        end
        rec_reg <= rec_next;
    end

    `TSD_ASSERT_IMP(a_cnt_max, aclk, aresetn, 1'b1, cnt_reg <= CW'(tsdsp_pkg::MaxDesc))
    `TSD_ASSERT_IMP(a_ovf_full, aclk, aresetn, ovf_reg, cnt_reg == CW'(tsdsp_pkg::MaxDesc))
    `TSD_ASSERT_NXT(a_clear, aclk, aresetn, cmd.clear, pos_reg == '0 && cnt_reg == '0)
    `TSD_ASSERT_IMP(a_skip_phase, aclk, aresetn, ph_reg == tsdsp_pkg::PH_SKIP,
                    skip_reg != 9'd0)
endmodule

// ----- sv/tsdsp_ctrl.sv -----
// Controller: accepts bytes, then sequences the summary and descriptor records.
// Depends on tsdsp_pkg.
`timescale 1ns / 1ps
`include "ts_description_section_parser_core_assert.svh"
module tsdsp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic             cfg_ready,
    input  tsdsp_pkg::stat_t stat,
    output tsdsp_pkg::cmd_t  cmd
);
    typedef enum logic [3:0] {
        S_IN = 4'b0001, S_SUM = 4'b0010, S_RD = 4'b0100, S_DESC = 4'b1000
    } state_t;

    localparam int IW = tsdsp_pkg::IdxW;
    localparam int CW = tsdsp_pkg::CntW;

    state_t st_reg, st_next;
    logic [CW-1:0] idx_reg, idx_next, n_reg, n_next;
    logic mv_reg, mv_next;

    logic acc, oacc;
    assign acc  = s_tvalid && s_tready;
    assign oacc = m_tvalid && m_tready;
    assign s_tready = (st_reg == S_IN) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign cfg_ready = (st_reg == S_IN) && !mv_reg;

    always_comb begin
        st_next = st_reg; idx_next = idx_reg; n_next = n_reg; mv_next = mv_reg;
        cmd = '0;
        cmd.rd_idx = idx_reg[IW-1:0];
        if (oacc) mv_next = 1'b0;
        unique case (st_reg)
            S_IN: begin
                cmd.take_byte = acc;
                if (acc && s_tlast) begin
                    cmd.load_out = 1'b1;
                    cmd.clear = 1'b1;
                    mv_next = 1'b1;
                    n_next = stat.pass ? stat.count : '0;
                    idx_next = '0;
                    st_next = S_SUM;
                end
            end
            S_SUM: begin
                if (oacc) st_next = (n_reg == '0) ? S_IN : S_RD;
            end
            S_RD: begin
                cmd.rd_en = 1'b1;
                st_next = S_DESC;
            end
            default: begin
                if (!mv_reg) begin
                    cmd.load_out = 1'b1;
                    cmd.out_desc = 1'b1;
                    cmd.out_last = (idx_reg + CW'(1) == n_reg);
                    mv_next = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end else if (oacc) begin
                    st_next = (idx_reg == n_reg) ? S_IN : S_RD;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IN; idx_reg <= '0; n_reg <= '0; mv_reg <= 1'b0;
        end else begin
            st_reg <= st_next; idx_reg <= idx_next; n_reg <= n_next; mv_reg <= mv_next;
        end
    end

    `TSD_ASSERT_IMP(a_no_in_busy, aclk, aresetn, st_reg != S_IN, !s_tready)
    `TSD_ASSERT_IMP(a_idx_le_n, aclk, aresetn, 1'b1, idx_reg <= n_reg)
    `TSD_ASSERT_NXT(a_last_load, aclk, aresetn, acc && s_tlast, st_reg == S_SUM && mv_reg)
endmodule

// ----- sv/ts_description_section_parser_core.sv -----
// Top level of the section parser: controller plus datapath.
// Depends on tsdsp_pkg, tsdsp_ctrl, tsdsp_datapath, tsdsp_ram.
//
// Channel  Dir  Payload
// s_       in   tdata[7:0] byte_value, tlast last_byte
// m_       out  tdata[93:0] fields, tlast last_record, tuser record_kind
// cfg_     in   cfg_data[12:0] min_section_bytes
//
// One byte per cycle while a section streams in; the CRC and walker update per byte.
// The summary record is valid the cycle after the last byte; each descriptor record
// then goes through a table RAM read, an output load and a valid phase, in which
// any m_tready stall holds every record.
// Input and config are held off until the last record is taken.
// aresetn is synchronous and active low.
`timescale 1ns / 1ps
module ts_description_section_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], tbl_id[9:2], header_flags[13:10], sec_len[25:14],
    // reserved_bits[43:26], ver_num[48:44], current_next[49],
    // sec_num[57:50], last_sec_num[65:58], entry_word[93:66]
    output logic [95:0] m_tdata,
    output logic        m_tuser,   // record_kind
    output logic        m_tlast,   // last_record
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data
);
    tsdsp_pkg::cmd_t  cmd;
    tsdsp_pkg::stat_t stat;
    logic [95:0] rec;
    logic [12:0] min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) min_reg <= 13'd12;
        else if (cfg_valid && cfg_ready) min_reg <= cfg_data;
    end

    tsdsp_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tlast, .m_tvalid, .m_tready,
        .cfg_ready, .stat, .cmd);

    tsdsp_datapath u_dp (
        .aclk, .aresetn, .min_bytes(min_reg), .byte_in(s_tdata), .cmd, .stat,
        .rec_data(rec));

    assign m_tuser = rec[0];
    assign m_tlast = rec[95];
    assign m_tdata = {2'b00, rec[94:1]};
endmodule
